[hw/rtl/sscd_pkg.sv]
// sscd_pkg: shared types, command characters and segment decode
// for the seven-segment command display core
// no dependencies
package sscd_pkg;

   localparam int TimerWidth = 16;
   localparam int CodeWidth  = 5;

   localparam logic [TimerWidth-1:0] BlankTicksReset = 16'd320;
   localparam logic [TimerWidth-1:0] EndTicksReset   = 16'd1600;
   localparam logic [TimerWidth-1:0] DimTicksReset   = 16'd800;

   // command characters
   localparam logic [7:0] CmdInvertOn  = 8'h26; // '&'
   localparam logic [7:0] CmdInvertOff = 8'h24; // '$'
   localparam logic [7:0] CmdBlank     = 8'h25; // '%'
   localparam logic [7:0] CmdDim       = 8'h23; // '#'

   // display codes beyond the hex digits
   localparam logic [CodeWidth-1:0] CodeBlank = 5'h10;
   localparam logic [CodeWidth-1:0] CodeDash  = 5'h11;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_BLANK_TICKS = 2'd0,
      CSR_END_TICKS   = 2'd1,
      CSR_DIM_TICKS   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [TimerWidth-1:0] blank_ticks;
      logic [TimerWidth-1:0] end_ticks;
      logic [TimerWidth-1:0] dim_ticks;
   } cfg_type;

   typedef struct packed {
      logic                 time_tick;
      logic                 data_valid;
      logic [7:0]           data_byte;
   } poll_type;

   typedef struct packed {
      logic [CodeWidth-1:0] code;
      logic                 byte_taken;
   } result_type;

   // active-high segment pattern, bit0 is segment a
   function automatic logic [6:0] seg_decode(input logic [CodeWidth-1:0] code);
      logic [6:0] seg;
      seg = 7'h00;
      case (code)
         5'h00:   seg = 7'h3F;
         5'h01:   seg = 7'h06;
         5'h02:   seg = 7'h5B;
         5'h03:   seg = 7'h4F;
         5'h04:   seg = 7'h66;
         5'h05:   seg = 7'h6D;
         5'h06:   seg = 7'h7D;
         5'h07:   seg = 7'h07;
         5'h08:   seg = 7'h7F;
         5'h09:   seg = 7'h6F;
         5'h0A:   seg = 7'h77;
         5'h0B:   seg = 7'h7C;
         5'h0C:   seg = 7'h39;
         5'h0D:   seg = 7'h5E;
         5'h0E:   seg = 7'h79;
         5'h0F:   seg = 7'h71;
         CodeDash: seg = 7'h40;
         default: seg = 7'h00;
      endcase
      return seg;
   endfunction

endpackage

[hw/rtl/sscd_engine.sv]
// sscd_engine: timers, mode flags and digit state, updated once per poll
// produces the display code and byte-taken flag for the output stage
// depends on sscd_pkg
module sscd_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  sscd_pkg::poll_type  poll,
   input  sscd_pkg::cfg_type   cfg,
   output sscd_pkg::result_type result
);

   localparam int TW = sscd_pkg::TimerWidth;

   logic          blank_active_ff, blank_active_in;
   logic [TW-1:0] blank_count_ff,  blank_count_in;
   logic          end_pending_ff,  end_pending_in;
   logic [TW-1:0] end_count_ff,    end_count_in;
   logic          finished_ff,     finished_in;
   logic          dim_active_ff,   dim_active_in;
   logic [TW-1:0] dim_count_ff,    dim_count_in;
   logic          invert_mode_ff,  invert_mode_in;
   logic          digit_valid_ff,  digit_valid_in;
   logic [3:0]    digit_nibble_ff, digit_nibble_in;
   logic [1:0]    duty_phase_ff,   duty_phase_in;

   logic [TW-1:0] blank_dec, end_dec, dim_dec;
   logic          go;
   logic          taken;
   logic [sscd_pkg::CodeWidth-1:0] code;

   always_comb begin
      blank_dec = blank_count_ff;
      end_dec   = end_count_ff;
      dim_dec   = dim_count_ff;
      if (poll.time_tick && blank_active_ff && blank_count_ff != '0) begin
         blank_dec = blank_count_ff - TW'(1);
      end
      if (poll.time_tick && end_pending_ff && end_count_ff != '0) begin
         end_dec = end_count_ff - TW'(1);
      end
      if (poll.time_tick && dim_active_ff && dim_count_ff != '0) begin
         dim_dec = dim_count_ff - TW'(1);
      end

      blank_active_in = blank_active_ff;
      blank_count_in  = blank_dec;
      end_pending_in  = end_pending_ff;
      end_count_in    = end_dec;
      finished_in     = finished_ff;
      dim_active_in   = dim_active_ff;
      dim_count_in    = dim_dec;
      invert_mode_in  = invert_mode_ff;
      digit_valid_in  = digit_valid_ff;
      digit_nibble_in = digit_nibble_ff;
      taken           = 1'b0;
      go              = 1'b1;

      if (blank_active_ff) begin
         if (blank_dec == '0) begin
            blank_active_in = 1'b0;
         end else begin
            go = 1'b0;
         end
      end

      if (go) begin
         if (!poll.data_valid) begin
            if (end_pending_ff) begin
               if (end_dec == '0) begin
                  finished_in = 1'b1;
               end
            end else begin
               end_pending_in = 1'b1;
               end_count_in   = cfg.end_ticks;
            end
         end else begin
            if (dim_active_ff && dim_dec == '0) begin
               dim_active_in = 1'b0;
            end
            taken          = 1'b1;
            end_pending_in = 1'b0;
            finished_in    = 1'b0;
            case (poll.data_byte)
               sscd_pkg::CmdInvertOn: begin
                  invert_mode_in = 1'b1;
               end
               sscd_pkg::CmdInvertOff: begin
                  invert_mode_in = 1'b0;
               end
               sscd_pkg::CmdBlank: begin
                  blank_active_in = 1'b1;
                  blank_count_in  = cfg.blank_ticks;
                  digit_valid_in  = 1'b0;
               end
               sscd_pkg::CmdDim: begin
                  dim_active_in = 1'b1;
                  dim_count_in  = cfg.dim_ticks;
               end
               default: begin
                  digit_valid_in  = 1'b1;
                  digit_nibble_in = poll.data_byte[3:0];
               end
            endcase
         end
      end

      // display code from the updated state
      if (digit_valid_in) begin
         code = {1'b0, invert_mode_in ? ~digit_nibble_in : digit_nibble_in};
      end else begin
         code = sscd_pkg::CodeBlank;
      end

      duty_phase_in = 2'd0;
      if (dim_active_in) begin
         if (duty_phase_ff != 2'd3) begin
            duty_phase_in = duty_phase_ff + 2'd1;
            code          = sscd_pkg::CodeBlank;
         end
      end

      if (blank_active_in) begin
         code = sscd_pkg::CodeBlank;
      end
      if (finished_in) begin
         code = sscd_pkg::CodeDash;
      end

      result.code       = code;
      result.byte_taken = taken;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blank_active_ff <= 1'b0;
         blank_count_ff  <= '0;
         end_pending_ff  <= 1'b0;
         end_count_ff    <= '0;
         finished_ff     <= 1'b0;
         dim_active_ff   <= 1'b0;
         dim_count_ff    <= '0;
         invert_mode_ff  <= 1'b0;
         digit_valid_ff  <= 1'b0;
         digit_nibble_ff <= '0;
         duty_phase_ff   <= '0;
      end else if (step) begin
         blank_active_ff <= blank_active_in;
         blank_count_ff  <= blank_count_in;
         end_pending_ff  <= end_pending_in;
         end_count_ff    <= end_count_in;
         finished_ff     <= finished_in;
         dim_active_ff   <= dim_active_in;
         dim_count_ff    <= dim_count_in;
         invert_mode_ff  <= invert_mode_in;
         digit_valid_ff  <= digit_valid_in;
         digit_nibble_ff <= digit_nibble_in;
         duty_phase_ff   <= duty_phase_in;
      end
   end

   // state only moves on a poll
   assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable({blank_active_ff, blank_count_ff, end_pending_ff, end_count_ff,
                         finished_ff, dim_active_ff, dim_count_ff, invert_mode_ff,
                         digit_valid_ff, digit_nibble_ff, duty_phase_ff}))
      else $error("engine state changed without a poll");

   // the dash and blanking never coexist
   assert property (@(posedge clock) disable iff (reset)
      !(blank_active_ff && finished_ff))
      else $error("finished while blanked");

   // duty phase runs only in dim mode
   assert property (@(posedge clock) disable iff (reset)
      duty_phase_ff != 2'd0 |-> dim_active_ff)
      else $error("duty phase outside dim mode");

endmodule

[hw/rtl/sscd_out_stage.sv]
// sscd_out_stage: result register, decodes the display code to
// active-low segments and holds the transfer until taken
// depends on sscd_pkg
module sscd_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  sscd_pkg::result_type result,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [7:0]           rsp_tdata,
   output logic                 ready
);

   logic       valid_ff,    valid_in;
   logic [6:0] segments_ff, segments_in;
   logic       taken_ff,    taken_in;

   assign ready       = !valid_ff || rsp_tready;
   assign valid_in    = load || (valid_ff && !rsp_tready);
   assign segments_in = ~sscd_pkg::seg_decode(result.code);
   assign taken_in    = result.byte_taken;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         segments_ff <= segments_in;
         taken_ff    <= taken_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {taken_ff, segments_ff};

endmodule

[hw/rtl/seven_segment_command_display_core.sv]
// seven_segment_command_display_core: top level with poll input register,
// configuration registers, state engine and result register
// depends on sscd_pkg, sscd_engine, sscd_out_stage

// One poll enters per req transfer and gives exactly one rsp transfer.
// Throughput is one poll per clock while rsp_tready does not stall the
// result register. rsp_tvalid rises once the poll has passed the input
// register, then the state update and segment decode into the result
// register. The poll state advances only when a poll moves from the input
// register into the result register. Configuration writes take effect at
// the next poll and are meant for idle periods.
module seven_segment_command_display_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [0] time_tick, [8:1] data_byte, [15:9] zero
   input  logic        req_tuser,  // [0] data_valid
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // [6:0] segments, [7] byte_taken
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic               in_valid_ff, in_valid_in;
   sscd_pkg::poll_type poll_ff;
   sscd_pkg::cfg_type  cfg_ff;
   sscd_pkg::result_type result;
   logic               out_ready;
   logic               step;

   assign step        = in_valid_ff && out_ready;
   assign req_tready  = !in_valid_ff || out_ready;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         poll_ff.time_tick  <= req_tdata[0];
         poll_ff.data_valid <= req_tuser;
         poll_ff.data_byte  <= req_tdata[8:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blank_ticks <= sscd_pkg::BlankTicksReset;
         cfg_ff.end_ticks   <= sscd_pkg::EndTicksReset;
         cfg_ff.dim_ticks   <= sscd_pkg::DimTicksReset;
      end else if (csr_we) begin
         unique case (csr_index)
            sscd_pkg::CSR_BLANK_TICKS: cfg_ff.blank_ticks <= csr_wdata;
            sscd_pkg::CSR_END_TICKS:   cfg_ff.end_ticks   <= csr_wdata;
            sscd_pkg::CSR_DIM_TICKS:   cfg_ff.dim_ticks   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   sscd_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .poll   (poll_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   sscd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .result     (result),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .ready      (out_ready)
   );

   // a held poll is never dropped
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_ready |=> in_valid_ff)
      else $error("held poll lost");

   // a poll with no byte offered never reports the byte taken
   assert property (@(posedge clock) disable iff (reset)
      step && !poll_ff.data_valid |=> !rsp_tdata[7])
      else $error("byte taken on an empty poll");

   // every poll step lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_tvalid)
      else $error("poll step without result");

endmodule

[bench/sscd_checker.sv]
// sscd_checker: watches the poll and result streams of the seven-segment
// command display core, predicts each result and compares it field by field
// depends on sscd_pkg
`timescale 1ns / 1ps
module sscd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,  // [0] time_tick, [8:1] data_byte, [15:9] zero
   input  logic        req_tuser,  // [0] data_valid
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,  // [6:0] segments, [7] byte_taken
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          open_polls
);

   typedef struct packed {
      logic       byte_taken;
      logic [6:0] segments;
   } shown_type;

   // lit segments per display code, active high
   logic [6:0] lit_pattern [18] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F,
      7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h00, 7'h40
   };

   logic [15:0] blank_period, end_period, dim_period;
   logic [15:0] blank_left, end_left, dim_left;
   logic        blank_on, end_armed, dash_on, dim_on, inverted, have_digit;
   logic [3:0]  nibble;
   logic [1:0]  dim_phase;
   shown_type   expected_display_q [$];

   task automatic advance_display(input logic tick, input logic present,
                                  input logic [7:0] value, output shown_type shown);
      logic [sscd_pkg::CodeWidth-1:0] code;
      logic                           go;
      go = 1'b1;
      shown.byte_taken = 1'b0;
      if (blank_on && tick && blank_left != 16'd0) blank_left = blank_left - 16'd1;
      if (end_armed && tick && end_left != 16'd0) end_left = end_left - 16'd1;
      if (dim_on && tick && dim_left != 16'd0) dim_left = dim_left - 16'd1;

      if (blank_on) begin
         if (blank_left == 16'd0) blank_on = 1'b0;
         else go = 1'b0;
      end

      if (go) begin
         if (!present) begin
            if (end_armed) begin
               if (end_left == 16'd0) dash_on = 1'b1;
            end else begin
               end_armed = 1'b1;
               end_left = end_period;
            end
         end else begin
            if (dim_on && dim_left == 16'd0) dim_on = 1'b0;
            shown.byte_taken = 1'b1;
            end_armed = 1'b0;
            dash_on = 1'b0;
            case (value)
               sscd_pkg::CmdInvertOn:  inverted = 1'b1;
               sscd_pkg::CmdInvertOff: inverted = 1'b0;
               sscd_pkg::CmdBlank: begin
                  blank_on = 1'b1;
                  blank_left = blank_period;
                  have_digit = 1'b0;
               end
               sscd_pkg::CmdDim: begin
                  dim_on = 1'b1;
                  dim_left = dim_period;
               end
               default: begin
                  have_digit = 1'b1;
                  nibble = value[3:0];
               end
            endcase
         end
      end

      code = have_digit ? {1'b0, (inverted ? ~nibble : nibble)} : sscd_pkg::CodeBlank;
      if (dim_on) begin
         if (dim_phase == 2'd3) begin
            dim_phase = 2'd0;
         end else begin
            dim_phase = dim_phase + 2'd1;
            code = sscd_pkg::CodeBlank;
         end
      end else begin
         dim_phase = 2'd0;
      end
      if (blank_on) code = sscd_pkg::CodeBlank;
      if (dash_on) code = sscd_pkg::CodeDash;
      shown.segments = ~lit_pattern[code];
   endtask

   always @(posedge clock) begin
      shown_type seen;
      shown_type wanted;
      shown_type shown;
      if (reset) begin
         blank_period = sscd_pkg::BlankTicksReset;
         end_period = sscd_pkg::EndTicksReset;
         dim_period = sscd_pkg::DimTicksReset;
         blank_on = 1'b0;
         blank_left = 16'd0;
         end_armed = 1'b0;
         end_left = 16'd0;
         dash_on = 1'b0;
         dim_on = 1'b0;
         dim_left = 16'd0;
         inverted = 1'b0;
         have_digit = 1'b0;
         nibble = 4'd0;
         dim_phase = 2'd0;
         expected_display_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               sscd_pkg::CSR_BLANK_TICKS: blank_period = csr_wdata;
               sscd_pkg::CSR_END_TICKS:   end_period = csr_wdata;
               sscd_pkg::CSR_DIM_TICKS:   dim_period = csr_wdata;
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (expected_display_q.size() == 0) begin
               $display("%0t: unexpected result transfer, expected none, actual %h",
                        $time, rsp_tdata);
               fail_count = fail_count + 1;
            end else begin
               wanted = expected_display_q.pop_front();
               if (seen.segments !== wanted.segments) begin
                  $display("%0t: segments mismatch, expected %h actual %h",
                           $time, wanted.segments, seen.segments);
                  fail_count = fail_count + 1;
               end
               if (seen.byte_taken !== wanted.byte_taken) begin
                  $display("%0t: byte_taken mismatch, expected %b actual %b",
                           $time, wanted.byte_taken, seen.byte_taken);
                  fail_count = fail_count + 1;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            advance_display(req_tdata[0], req_tuser, req_tdata[8:1], shown);
            expected_display_q.push_back(shown);
         end
      end
      open_polls = expected_display_q.size();
   end

endmodule

[bench/seven_segment_command_display_core_tb.sv]
// seven_segment_command_display_core_tb: drives polls and configuration
// writes into the display core and gives the verdict from sscd_checker
// depends on sscd_pkg, sscd_checker and the core
`timescale 1ns / 1ps
module seven_segment_command_display_core_tb;

   localparam int         CycleLimit    = 1000000;
   localparam int         HoldCycles    = 300;
   localparam int         DrainCycles   = 8;
   localparam logic [1:0] CsrNoRegister = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = 16'd0;  // [0] time_tick, [8:1] data_byte, [15:9] zero
   logic        req_tuser = 1'b0;   // [0] data_valid
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // [6:0] segments, [7] byte_taken
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [15:0] csr_wdata = 16'd0;

   int fail_count;
   int open_polls;
   int cycle_count = 0;
   int tick_pct = 50;
   bit idling_on = 1'b1;
   bit hold_wanted = 1'b0;

   seven_segment_command_display_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   sscd_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .open_polls (open_polls)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count = cycle_count + 1;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int stall;
      bit held;
      held = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = idling_on ? $urandom_range(0, 17) : 0;
         if (hold_wanted && !held) begin
            held = 1'b1;
            stall = HoldCycles;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_poll(input bit tick, input bit present, input logic [7:0] value);
      int gap;
      gap = idling_on ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, value, tick};
      req_tuser <= present;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (open_polls != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [15:0] blank_ticks, input logic [15:0] end_ticks,
                             input logic [15:0] dim_ticks);
      write_reg(sscd_pkg::CSR_BLANK_TICKS, blank_ticks);
      write_reg(sscd_pkg::CSR_END_TICKS, end_ticks);
      write_reg(sscd_pkg::CSR_DIM_TICKS, dim_ticks);
      if ($urandom_range(0, 1)) write_reg(CsrNoRegister, 16'($urandom));
   endtask

   task automatic random_phase(input int count, input bit steady);
      int empty_left;
      int sent;
      bit tick;
      logic [7:0] value;
      empty_left = 0;
      sent = 0;
      if (steady) idling_on <= 1'b0;
      while (sent < count) begin
         if (!steady && sent % 60 == 0) idling_on <= ($urandom_range(0, 3) != 0);
         if (empty_left == 0 && $urandom_range(0, 19) == 0)
            empty_left = $urandom_range(3, 40);
         tick = ($urandom_range(0, 99) < tick_pct);
         value = 8'($urandom_range(0, 255));
         if (empty_left > 0) begin
            empty_left = empty_left - 1;
            send_poll(tick, 1'b0, value);
         end else begin
            case ($urandom_range(0, 11))
               0: value = sscd_pkg::CmdInvertOn;
               1: value = sscd_pkg::CmdInvertOff;
               2: value = sscd_pkg::CmdBlank;
               3: value = sscd_pkg::CmdDim;
               default: ;
            endcase
            send_poll(tick, $urandom_range(0, 9) != 0, value);
         end
         sent = sent + 1;
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset configuration: digits, extremes, invert, dim duty, blank
      send_poll(1'b1, 1'b0, 8'hFF);
      send_poll(1'b0, 1'b1, 8'h00);
      send_poll(1'b1, 1'b1, 8'hFF);
      send_poll(1'b0, 1'b1, 8'h3A);
      send_poll(1'b0, 1'b1, sscd_pkg::CmdInvertOn);
      send_poll(1'b1, 1'b1, 8'h35);
      send_poll(1'b0, 1'b1, sscd_pkg::CmdInvertOff);
      send_poll(1'b0, 1'b1, sscd_pkg::CmdDim);
      send_poll(1'b0, 1'b1, 8'h31);
      send_poll(1'b0, 1'b1, 8'h32);
      send_poll(1'b0, 1'b0, 8'h00);
      send_poll(1'b0, 1'b1, 8'h37);
      send_poll(1'b0, 1'b1, sscd_pkg::CmdBlank);
      send_poll(1'b1, 1'b1, 8'h39);

      // shortest timeouts: blank expiry, end-of-data dash, late dim expiry
      settle();
      set_config(16'd1, 16'd1, 16'd1);
      send_poll(1'b0, 1'b1, sscd_pkg::CmdBlank);
      send_poll(1'b1, 1'b1, 8'h38);
      send_poll(1'b1, 1'b0, 8'h00);
      send_poll(1'b1, 1'b0, 8'h00);
      send_poll(1'b0, 1'b0, 8'h00);
      send_poll(1'b0, 1'b1, 8'h34);
      send_poll(1'b0, 1'b1, sscd_pkg::CmdDim);
      send_poll(1'b1, 1'b0, 8'h00);
      send_poll(1'b0, 1'b1, 8'h36);

      // zero periods and a write to an unused index
      settle();
      set_config(16'd0, 16'd0, 16'd0);
      write_reg(CsrNoRegister, 16'hFFFF);
      send_poll(1'b0, 1'b1, sscd_pkg::CmdBlank);
      send_poll(1'b0, 1'b1, 8'h31);
      send_poll(1'b0, 1'b0, 8'h00);
      send_poll(1'b0, 1'b0, 8'h00);

      settle();
      set_config(16'd1, 16'd1, 16'd1);
      random_phase(250, 1'b0);
      settle();
      set_config(16'd0, 16'd0, 16'd0);
      random_phase(150, 1'b0);
      settle();
      set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_phase(80, 1'b0);
      for (int phase = 0; phase < 6; phase++) begin
         settle();
         set_config(16'($urandom_range(0, 15)), 16'($urandom_range(0, 40)),
                    16'($urandom_range(0, 20)));
         tick_pct = $urandom_range(20, 90);
         if (phase == 2) hold_wanted <= 1'b1;
         random_phase(180, phase == 2);
      end
      settle();
      set_config(sscd_pkg::BlankTicksReset, sscd_pkg::EndTicksReset,
                 sscd_pkg::DimTicksReset);
      tick_pct = 95;
      random_phase(200, 1'b0);
      settle();

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[seven_segment_command_display_core.f]
hw/rtl/sscd_pkg.sv
hw/rtl/sscd_engine.sv
hw/rtl/sscd_out_stage.sv
hw/rtl/seven_segment_command_display_core.sv
bench/sscd_checker.sv
bench/seven_segment_command_display_core_tb.sv
